### design/nhfp_pkg.sv
package nhfp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MU_FRAC   = 8;
  localparam int LN_FRAC   = 30;
  localparam int LN_TERMS  = 12;

  localparam int FIX_W  = 32;
  localparam int OUT_W  = 64;
  localparam int MAG_W  = 64;
  localparam int DET_W  = 98;
  localparam int JQ_W   = 96 - 2 * FRAC_BITS;
  localparam int K_W    = $clog2(JQ_W);
  localparam int LNJ_W  = 40;
  localparam int COEF_SH = MU_FRAC + LN_FRAC - FRAC_BITS;
  localparam int COEF_W = FIX_W + LNJ_W - COEF_SH;
  localparam int ACC_W  = 128;

  localparam int DET_LAT = 4;
  localparam int DIV_LAT = MAG_W + 1;
  localparam int LN_LAT  = 2 + LN_FRAC + 1 + LN_TERMS + 3;
  localparam int OUT_LAT = 3;

  localparam logic [0:0] REG_SHEAR  = 1'b0;
  localparam logic [0:0] REG_LAMBDA = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SINGULAR  = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef logic signed [FIX_W-1:0]  fix_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [JQ_W-1:0]          jq_t;
  typedef logic signed [OUT_W-1:0]  wide_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [3:0]               idx_t;

  typedef struct packed {
    jq_t  jq;
    logic sing;
  } det_info_t;

  // cofactor i = f[a]*f[b] - f[c]*f[d]
  localparam idx_t COF_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4}, '{4'd2, 4'd3, 4'd0, 4'd5}, '{4'd0, 4'd4, 4'd1, 4'd3}};

endpackage

### design/nhfp_det.sv
module nhfp_det import nhfp_pkg::*; (
  input  logic      clk,
  input  fix_t      grad [9],
  output fix_t      f_out [9],
  output mag_t      cmag [9],
  output logic      cneg [9],
  output det_info_t info
);

  fix_t f1 [9];
  fix_t f2 [9];
  fix_t f3 [9];
  logic signed [63:0] p1 [9];
  logic signed [63:0] p2 [9];
  logic signed [64:0] diff [9];
  mag_t cmag2 [9];
  mag_t cmag3 [9];
  logic cneg2 [9];
  logic cneg3 [9];
  logic [31:0] af [3];
  logic [63:0] pl [3];
  logic [63:0] ph [3];
  logic nf [3];
  logic [95:0] mag [3];
  logic signed [DET_W-1:0] term [3];
  logic signed [DET_W-1:0] det;
  jq_t jq_c;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      diff[i] = 65'(p1[i]) - 65'(p2[i]);
    end
    for (int i = 0; i < 3; i++) begin
      af[i] = f2[i][FIX_W-1] ? 32'(-f2[i]) : 32'(f2[i]);
      mag[i] = (96'(ph[i]) << 32) + 96'(pl[i]);
      term[i] = nf[i] ? -(DET_W'(mag[i])) : DET_W'(mag[i]);
    end
    det = term[0] + term[1] + term[2];
    jq_c = det[DET_W-1] ? '0 : det[2*FRAC_BITS +: JQ_W];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      f1[i] <= grad[i];
      p1[i] <= grad[COF_IDX[i][0]] * grad[COF_IDX[i][1]];
      p2[i] <= grad[COF_IDX[i][2]] * grad[COF_IDX[i][3]];
      f2[i] <= f1[i];
      cneg2[i] <= diff[i][64];
      cmag2[i] <= diff[i][64] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      f3[i] <= f2[i];
      cmag3[i] <= cmag2[i];
      cneg3[i] <= cneg2[i];
      f_out[i] <= f3[i];
      cmag[i] <= cmag3[i];
      cneg[i] <= cneg3[i];
    end
    for (int i = 0; i < 3; i++) begin
      pl[i] <= af[i] * cmag2[i][31:0];
      ph[i] <= af[i] * cmag2[i][63:32];
      nf[i] <= f2[i][FIX_W-1] ^ cneg2[i];
    end
    info.jq <= jq_c;
    info.sing <= (jq_c <= JQ_W'(1));
  end

endmodule

### design/nhfp_div.sv
module nhfp_div import nhfp_pkg::*; (
  input  logic  clk,
  input  mag_t  num,
  input  logic  neg,
  input  jq_t   den,
  output wide_t quo
);

  mag_t nq_r [1:MAG_W];
  jq_t  rm_r [1:MAG_W];
  jq_t  dv_r [1:MAG_W];
  logic sg_r [1:MAG_W];
  mag_t nq_c [0:MAG_W-1];
  jq_t  rm_c [0:MAG_W-1];
  jq_t  dv_c [0:MAG_W-1];
  logic sg_c [0:MAG_W-1];
  logic [JQ_W:0] trial [0:MAG_W-1];
  logic ge [0:MAG_W-1];
  logic up;
  mag_t qr;

  always_comb begin
    nq_c[0] = num;
    rm_c[0] = '0;
    dv_c[0] = den;
    sg_c[0] = neg;
    for (int s = 1; s < MAG_W; s++) begin
      nq_c[s] = nq_r[s];
      rm_c[s] = rm_r[s];
      dv_c[s] = dv_r[s];
      sg_c[s] = sg_r[s];
    end
    for (int s = 0; s < MAG_W; s++) begin
      trial[s] = {rm_c[s], nq_c[s][MAG_W-1]};
      ge[s] = trial[s] >= {1'b0, dv_c[s]};
    end
    up = {rm_r[MAG_W], 1'b0} >= {1'b0, dv_r[MAG_W]};
    qr = nq_r[MAG_W] + MAG_W'(up);
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < MAG_W; s++) begin
      nq_r[s+1] <= {nq_c[s][MAG_W-2:0], ge[s]};
      rm_r[s+1] <= ge[s] ? JQ_W'(trial[s] - {1'b0, dv_c[s]}) : trial[s][JQ_W-1:0];
      dv_r[s+1] <= dv_c[s];
      sg_r[s+1] <= sg_c[s];
    end
    quo <= sg_r[MAG_W] ? -$signed(qr) : $signed(qr);
  end

endmodule

### design/nhfp_ln.sv
module nhfp_ln import nhfp_pkg::*; (
  input  logic               clk,
  input  jq_t                jq,
  input  logic signed [31:0] lambda,
  output coef_t              coef
);

  localparam int ZN   = LN_FRAC;
  localparam int ZR_W = LN_FRAC + 2;
  localparam int MM_W = LN_FRAC + 1;
  localparam int KD   = ZN + LN_TERMS + 2;
  localparam int R_W  = 36;
  localparam int RS   = 35;
  localparam int SUM_W = LN_FRAC + 1;
  localparam logic [LNJ_W-1:0] LN2 = LNJ_W'(744261118);
  localparam logic [ACC_W-1:0] ONE_R = 128'd1 << RS;
  localparam logic [R_W-1:0] RECIP [LN_TERMS] = '{
    R_W'(ONE_R),
    R_W'((ONE_R + 128'd2) / 128'd3),
    R_W'((ONE_R + 128'd4) / 128'd5),
    R_W'((ONE_R + 128'd6) / 128'd7),
    R_W'((ONE_R + 128'd8) / 128'd9),
    R_W'((ONE_R + 128'd10) / 128'd11),
    R_W'((ONE_R + 128'd12) / 128'd13),
    R_W'((ONE_R + 128'd14) / 128'd15),
    R_W'((ONE_R + 128'd16) / 128'd17),
    R_W'((ONE_R + 128'd18) / 128'd19),
    R_W'((ONE_R + 128'd20) / 128'd21),
    R_W'((ONE_R + 128'd22) / 128'd23)};

  logic [K_W-1:0] k_c;
  logic [K_W-1:0] k1;
  logic [K_W-1:0] k2;
  jq_t jq1;
  logic [MM_W-1:0] mm_c;
  logic [MM_W-1:0] mm2;
  logic [ZR_W-1:0] zrm_r [1:ZN];
  logic [ZR_W-1:0] zdv_r [1:ZN];
  logic [ZN-1:0]   zq_r  [1:ZN];
  logic [ZR_W-1:0] zrm_c [0:ZN-1];
  logic [ZR_W-1:0] zdv_c [0:ZN-1];
  logic [ZN-1:0]   zq_c  [0:ZN-1];
  logic [ZR_W:0]   ztrial [0:ZN-1];
  logic            zge [0:ZN-1];
  logic [K_W-1:0]  kd [KD];
  logic [2*LN_FRAC-1:0] zz;
  logic [LN_FRAC-1:0] term_r [0:LN_TERMS];
  logic [LN_FRAC-1:0] z2_r [0:LN_TERMS];
  logic [SUM_W-1:0]   sum_r [0:LN_TERMS];
  logic [LN_FRAC-1:0] qp_r [0:LN_TERMS];
  logic [2*LN_FRAC-1:0] prod_t [LN_TERMS];
  logic [LN_FRAC+R_W-1:0] prod_q [LN_TERMS];
  logic [SUM_W-1:0] sum_f;
  logic signed [K_W:0] ke;
  logic signed [LNJ_W-1:0] lnj;
  logic signed [FIX_W+LNJ_W-1:0] lp;

  always_comb begin
    k_c = '0;
    for (int i = 1; i < JQ_W; i++) begin
      if (jq[i]) begin
        k_c = K_W'(i);
      end
    end
    mm_c = (k1 > K_W'(LN_FRAC)) ? MM_W'(jq1 >> (k1 - K_W'(LN_FRAC)))
                                : MM_W'(jq1 << (K_W'(LN_FRAC) - k1));
    zrm_c[0] = {2'b00, mm2[LN_FRAC-1:0]};
    zdv_c[0] = {2'b10, mm2[LN_FRAC-1:0]};
    zq_c[0] = '0;
    for (int s = 1; s < ZN; s++) begin
      zrm_c[s] = zrm_r[s];
      zdv_c[s] = zdv_r[s];
      zq_c[s] = zq_r[s];
    end
    for (int s = 0; s < ZN; s++) begin
      ztrial[s] = {zrm_c[s], 1'b0};
      zge[s] = ztrial[s] >= {1'b0, zdv_c[s]};
    end
    zz = zq_r[ZN] * zq_r[ZN];
    for (int n = 0; n < LN_TERMS; n++) begin
      prod_t[n] = term_r[n] * z2_r[n];
      prod_q[n] = term_r[n] * RECIP[n];
    end
    ke = $signed({1'b0, kd[KD-1]}) - (K_W+1)'(FRAC_BITS);
    lp = lambda * lnj;
  end

  always_ff @(posedge clk) begin
    jq1 <= jq;
    k1 <= k_c;
    k2 <= k1;
    mm2 <= mm_c;
    for (int s = 0; s < ZN; s++) begin
      zrm_r[s+1] <= zge[s] ? ZR_W'(ztrial[s] - {1'b0, zdv_c[s]}) : ztrial[s][ZR_W-1:0];
      zdv_r[s+1] <= zdv_c[s];
      zq_r[s+1] <= {zq_c[s][ZN-2:0], zge[s]};
    end
    kd[0] <= k2;
    for (int i = 1; i < KD; i++) begin
      kd[i] <= kd[i-1];
    end
    term_r[0] <= zq_r[ZN];
    z2_r[0] <= zz[2*LN_FRAC-1:LN_FRAC];
    sum_r[0] <= '0;
    qp_r[0] <= '0;
    for (int n = 0; n < LN_TERMS; n++) begin
      term_r[n+1] <= prod_t[n][2*LN_FRAC-1:LN_FRAC];
      z2_r[n+1] <= z2_r[n];
      sum_r[n+1] <= sum_r[n] + SUM_W'(qp_r[n]);
      qp_r[n+1] <= prod_q[n][RS +: LN_FRAC];
    end
    sum_f <= sum_r[LN_TERMS] + SUM_W'(qp_r[LN_TERMS]);
    lnj <= LNJ_W'(ke) * LN2 + LNJ_W'({sum_f, 1'b0});
    coef <= lp[COEF_SH +: COEF_W];
  end

endmodule

### design/nhfp_out.sv
module nhfp_out import nhfp_pkg::*; (
  input  logic        clk,
  input  fix_t        f,
  input  wide_t       g,
  input  coef_t       coef,
  input  logic [31:0] mu,
  output wide_t       stress,
  output logic        sat
);

  localparam int CH_W = COEF_W - 32;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [OUT_W-1:0] SMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SMIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [OUT_W:0] d1;
  logic [63:0] pll1;
  logic signed [64:0] plh1;
  logic signed [CH_W+32:0] phl1;
  logic signed [CH_W+31:0] phh1;
  logic [ACC_W-1:0] t2_c;
  logic [ACC_W-1:0] t2;
  logic [63:0] ml2;
  logic signed [65:0] mh2;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0] sh;
  logic [ACC_W-OUT_W:0] hi;
  logic fit;

  always_comb begin
    t2_c = (ACC_W'(phh1) << 64) + ((ACC_W'(plh1) + ACC_W'(phl1)) << 32) + ACC_W'(pll1);
    acc = $signed((((ACC_W'(mh2) << 32) + ACC_W'(ml2)) << (FRAC_BITS - MU_FRAC)) + t2 + HALF);
    sh = ACC_W'(acc >>> FRAC_BITS);
    hi = sh[ACC_W-1:OUT_W-1];
    fit = (&hi) | ~(|hi);
  end

  always_ff @(posedge clk) begin
    d1 <= (OUT_W+1)'(f) - (OUT_W+1)'(g);
    pll1 <= coef[31:0] * g[31:0];
    plh1 <= $signed({1'b0, coef[31:0]}) * $signed(g[63:32]);
    phl1 <= $signed(coef[COEF_W-1:32]) * $signed({1'b0, g[31:0]});
    phh1 <= $signed(coef[COEF_W-1:32]) * $signed(g[63:32]);
    t2 <= t2_c;
    ml2 <= d1[31:0] * mu;
    mh2 <= $signed(d1[OUT_W:32]) * $signed({1'b0, mu});
    stress <= fit ? $signed(sh[OUT_W-1:0]) : $signed(sh[ACC_W-1] ? SMIN : SMAX);
    sat <= ~fit;
  end

endmodule

### design/neo_hookean_first_piola_stress.sv
// Throughput: one matrix per cycle; busy stays low, so start may be held high.
// The cofactor dividers (one quotient bit per stage, 64 stages) set the depth.
// Reset (rst, synchronous) clears both material registers and drops all beats in flight.
// done pulses for one cycle with the result; the receiver cannot stall.
module neo_hookean_first_piola_stress import nhfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               wr_en,
  input  logic [0:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic signed [31:0] grad_00,
  input  logic signed [31:0] grad_01,
  input  logic signed [31:0] grad_02,
  input  logic signed [31:0] grad_10,
  input  logic signed [31:0] grad_11,
  input  logic signed [31:0] grad_12,
  input  logic signed [31:0] grad_20,
  input  logic signed [31:0] grad_21,
  input  logic signed [31:0] grad_22,
  output logic               done,
  output logic signed [63:0] stress_00,
  output logic signed [63:0] stress_01,
  output logic signed [63:0] stress_02,
  output logic signed [63:0] stress_10,
  output logic signed [63:0] stress_11,
  output logic signed [63:0] stress_12,
  output logic signed [63:0] stress_20,
  output logic signed [63:0] stress_21,
  output logic signed [63:0] stress_22,
  output logic [1:0]         status
);

  localparam int TOT  = DET_LAT + DIV_LAT + OUT_LAT;
  localparam int SDLY = DIV_LAT + OUT_LAT;
  localparam int CDLY = DIV_LAT - LN_LAT;

  logic [31:0] shear_modulus;
  logic signed [31:0] lame_lambda;
  fix_t grad [9];
  fix_t f_det [9];
  mag_t cmag [9];
  logic cneg [9];
  det_info_t info;
  wide_t g [9];
  coef_t coef;
  coef_t coef_dly [CDLY];
  fix_t f_dly [DIV_LAT][9];
  logic sing_dly [SDLY];
  logic [TOT-1:0] vld;
  wide_t stress_o [9];
  logic [8:0] sat_o;
  wide_t res [9];

  assign busy = 1'b0;
  assign grad = '{grad_00, grad_01, grad_02, grad_10, grad_11, grad_12,
                  grad_20, grad_21, grad_22};

  always_ff @(posedge clk) begin
    if (rst) begin
      shear_modulus <= '0;
      lame_lambda <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SHEAR:  shear_modulus <= wr_data;
        REG_LAMBDA: lame_lambda <= $signed(wr_data);
      endcase
    end
  end

  nhfp_det u_det (
    .clk   (clk),
    .grad  (grad),
    .f_out (f_det),
    .cmag  (cmag),
    .cneg  (cneg),
    .info  (info)
  );

  for (genvar j = 0; j < 9; j++) begin : g_lane
    nhfp_div u_div (
      .clk (clk),
      .num (cmag[j]),
      .neg (cneg[j]),
      .den (info.jq),
      .quo (g[j])
    );
    nhfp_out u_out (
      .clk    (clk),
      .f      (f_dly[DIV_LAT-1][j]),
      .g      (g[j]),
      .coef   (coef_dly[CDLY-1]),
      .mu     (shear_modulus),
      .stress (stress_o[j]),
      .sat    (sat_o[j])
    );
  end

  nhfp_ln u_ln (
    .clk    (clk),
    .jq     (info.jq),
    .lambda (lame_lambda),
    .coef   (coef)
  );

  always_ff @(posedge clk) begin
    for (int j = 0; j < 9; j++) begin
      f_dly[0][j] <= f_det[j];
      for (int s = 1; s < DIV_LAT; s++) begin
        f_dly[s][j] <= f_dly[s-1][j];
      end
    end
    coef_dly[0] <= coef;
    for (int s = 1; s < CDLY; s++) begin
      coef_dly[s] <= coef_dly[s-1];
    end
    sing_dly[0] <= info.sing;
    for (int s = 1; s < SDLY; s++) begin
      sing_dly[s] <= sing_dly[s-1];
    end
    for (int j = 0; j < 9; j++) begin
      res[j] <= sing_dly[SDLY-1] ? '0 : stress_o[j];
    end
    if (sing_dly[SDLY-1]) begin
      status <= ST_SINGULAR;
    end else if (|sat_o) begin
      status <= ST_SATURATED;
    end else begin
      status <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[TOT-2:0], start & ~busy};
      done <= vld[TOT-1];
    end
  end

  assign stress_00 = res[0];
  assign stress_01 = res[1];
  assign stress_02 = res[2];
  assign stress_10 = res[3];
  assign stress_11 = res[4];
  assign stress_12 = res[5];
  assign stress_20 = res[6];
  assign stress_21 = res[7];
  assign stress_22 = res[8];

endmodule

### test/nhfp_checker.sv
`timescale 1ns / 1ps
module nhfp_checker import nhfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   wr_en,
  input  logic [0:0]             wr_index,
  input  logic [31:0]            wr_data,
  input  logic [8:0][31:0]       grad,
  input  logic                   done,
  input  logic [8:0][63:0]       stress,
  input  logic [1:0]             status,
  output int                     fails,
  output int                     pending
);

  typedef struct packed {
    logic [8:0][63:0] s;
    logic [1:0]       st;
  } piola_t;

  typedef logic signed [127:0] s128_t;

  localparam s128_t MAX64 = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam s128_t MIN64 = -128'sh8000_0000_0000_0000;
  localparam longint LN2_Q30 = 64'sd744261118;

  logic [31:0]        mu_q;
  logic signed [31:0] lam_q;
  piola_t             stress_q[$];

  assign pending = stress_q.size();

  function automatic s128_t ext32(input logic signed [31:0] x);
    s128_t r;
    r = x;
    return r;
  endfunction

  function automatic longint ln_j(input logic [63:0] jq);
    int k;
    logic [63:0] mm, z, z2, term, sum;
    k = 0;
    sum = 0;
    while (k < 63 && (jq >> (k + 1)) != 0) k++;
    mm = (k > LN_FRAC) ? (jq >> (k - LN_FRAC)) : (jq << (LN_FRAC - k));
    z = ((mm - (64'd1 << LN_FRAC)) << LN_FRAC) / (mm + (64'd1 << LN_FRAC));
    z2 = (z * z) >> LN_FRAC;
    term = z;
    for (int n = 0; n < LN_TERMS; n++) begin
      sum += term / (2 * n + 1);
      term = (term * z2) >> LN_FRAC;
    end
    return (longint'(k) - FRAC_BITS) * LN2_Q30 + longint'(2 * sum);
  endfunction

  function automatic piola_t piola(input logic [8:0][31:0] fv, input logic [31:0] mu,
                                  input logic signed [31:0] lam);
    piola_t res;
    s128_t f[9], cof[9], g[9];
    s128_t det, tmp, coef, d, t1, t2, acc, mu128;
    logic [63:0] jq, cmag, q, r;
    logic signed [63:0] c64;
    logic sat;
    det = 0;
    sat = 0;
    res = '0;
    for (int i = 0; i < 9; i++) f[i] = ext32(fv[i]);
    for (int i = 0; i < 9; i++)
      cof[i] = f[COF_IDX[i][0]] * f[COF_IDX[i][1]] - f[COF_IDX[i][2]] * f[COF_IDX[i][3]];
    for (int i = 0; i < 3; i++) det += f[i] * cof[i];
    tmp = det >>> (2 * FRAC_BITS);
    jq = (det < 0) ? 64'd0 : tmp[63:0];
    if (jq <= 1) begin
      res.st = ST_SINGULAR;
      return res;
    end
    for (int i = 0; i < 9; i++) begin
      tmp = (cof[i] < 0) ? -cof[i] : cof[i];
      cmag = tmp[63:0];
      q = cmag / jq;
      r = cmag % jq;
      if (r >= jq - r) q++;
      tmp = 0;
      tmp[63:0] = q;
      g[i] = (cof[i] < 0) ? -tmp : tmp;
    end
    tmp = ext32(lam) * s128_t'(ln_j(jq));
    tmp = tmp >>> COEF_SH;
    c64 = tmp[63:0];
    coef = c64;
    mu128 = 0;
    mu128[31:0] = mu;
    for (int i = 0; i < 9; i++) begin
      d = f[i] - g[i];
      t1 = (d * mu128) <<< (FRAC_BITS - MU_FRAC);
      t2 = coef * g[i];
      acc = (t1 + t2 + (s128_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (acc > MAX64) begin
        acc = MAX64;
        sat = 1;
      end else if (acc < MIN64) begin
        acc = MIN64;
        sat = 1;
      end
      res.s[i] = acc[63:0];
    end
    res.st = sat ? ST_SATURATED : ST_OK;
    return res;
  endfunction

  task automatic report(input string what, input int idx, input logic [63:0] got,
                        input logic [63:0] want);
    $display("MISMATCH %s[%0d]: got %h expected %h at %0t", what, idx, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    piola_t e;
    if (rst) begin
      mu_q <= '0;
      lam_q <= '0;
      stress_q.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == REG_SHEAR) mu_q <= wr_data;
        else if (wr_index == REG_LAMBDA) lam_q <= wr_data;
      end
      if (done) begin
        if (stress_q.size() == 0) begin
          report("unexpected beat", 0, 64'd0, 64'd0);
        end else begin
          e = stress_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (stress[i] !== e.s[i]) report("stress", i, stress[i], e.s[i]);
          if (status !== e.st) report("status", 0, 64'(status), 64'(e.st));
        end
      end
      if (start && !busy) stress_q.push_back(piola(grad, mu_q, lam_q));
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb import nhfp_pkg::*;;

  localparam int ONE = 1 << FRAC_BITS;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic               wr_en = 0;
  logic [0:0]         wr_index = REG_SHEAR;
  logic [31:0]        wr_data = 0;
  logic signed [31:0] g_r [9] = '{default: 0};
  logic               done;
  logic signed [63:0] s_r [9];
  logic [1:0]         status;
  int                 fails, pending;
  bit                 no_gaps;

  always #4 clk = ~clk;

  neo_hookean_first_piola_stress u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .grad_00(g_r[0]), .grad_01(g_r[1]), .grad_02(g_r[2]),
    .grad_10(g_r[3]), .grad_11(g_r[4]), .grad_12(g_r[5]),
    .grad_20(g_r[6]), .grad_21(g_r[7]), .grad_22(g_r[8]),
    .done(done),
    .stress_00(s_r[0]), .stress_01(s_r[1]), .stress_02(s_r[2]),
    .stress_10(s_r[3]), .stress_11(s_r[4]), .stress_12(s_r[5]),
    .stress_20(s_r[6]), .stress_21(s_r[7]), .stress_22(s_r[8]),
    .status(status)
  );

  nhfp_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .grad({g_r[8], g_r[7], g_r[6], g_r[5], g_r[4], g_r[3], g_r[2], g_r[1], g_r[0]}),
    .done(done),
    .stress({s_r[8], s_r[7], s_r[6], s_r[5], s_r[4], s_r[3], s_r[2], s_r[1], s_r[0]}),
    .status(status), .fails(fails), .pending(pending)
  );

  function automatic logic signed [31:0] noise(input int amp);
    return $signed($urandom_range(0, 2 * amp)) - amp;
  endfunction

  task automatic send(input logic signed [31:0] m [9]);
    int r, gap;
    start <= 1;
    for (int i = 0; i < 9; i++) g_r[i] <= m[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    @(posedge clk);
  endtask

  task automatic diag(input logic signed [31:0] a, b, c);
    logic signed [31:0] m [9];
    m = '{a, 0, 0, 0, b, 0, 0, 0, c};
    send(m);
  endtask

  task automatic directed();
    logic signed [31:0] m [9];
    diag(ONE, ONE, ONE);
    diag(0, 0, 0);
    diag(-ONE, ONE, ONE);
    diag(ONE, ONE, 1);
    diag(ONE, ONE, 2);
    diag(2 * ONE, 2 * ONE, 2 * ONE);
    diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    diag(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    m = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send(m);
    m = '{ONE, ONE / 2, 0, -ONE / 2, ONE, 0, 0, 0, ONE / 4};
    send(m);
    m = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};
    send(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send(m);
  endtask

  task automatic random_items(input int n);
    logic signed [31:0] m [9];
    int kind;
    for (int j = 0; j < n; j++) begin
      kind = $urandom_range(0, 99);
      for (int i = 0; i < 9; i++) begin
        if (kind < 60)
          m[i] = (i % 4 == 0) ? ONE + noise(ONE / 2) : noise(ONE / 4);
        else if (kind < 75)
          m[i] = noise(1 << 28);
        else if (kind < 90)
          m[i] = $urandom;
        else
          m[i] = (i % 4 == 0) ? $signed($urandom_range(0, 1 << 9)) : noise(4);
      end
      send(m);
    end
  endtask

  task automatic phase(input logic [31:0] mu, input logic [31:0] lam);
    drain();
    write_reg(REG_SHEAR, mu);
    write_reg(REG_LAMBDA, lam);
    no_gaps = ($urandom_range(0, 3) == 0);
    directed();
    random_items(55);
  endtask

  initial begin
    no_gaps = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed();
    random_items(30);
    phase(32'd25600, 32'd12800);
    phase(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    phase(32'd0, 32'h8000_0000);
    phase(32'd12345678, -32'sd777777);
    phase(32'd1, 32'd0);
    phase($urandom, $urandom);
    drain();
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
